FILE: rtl/tes_pkg.sv
// ----------------------------------------------------------------------------
// tes_pkg
// Shared types, codes and default sizes of the timed event scheduler.
// ----------------------------------------------------------------------------
package tes_pkg;

  // Default sizes.
  localparam int unsigned COMPONENTS_DEF  = 16;
  localparam int unsigned QUEUE_DEPTH_DEF = 16;
  localparam int unsigned TIMER_SLOTS_DEF = 4;
  localparam int unsigned TIME_BITS_DEF   = 48;

  // Fixed field widths.
  localparam int unsigned OP_W     = 2;
  localparam int unsigned COMP_W   = 4;
  localparam int unsigned SLOT_IN_W = 2;
  localparam int unsigned STATUS_W = 2;

  typedef logic [COMP_W-1:0]   comp_t;
  typedef logic [STATUS_W-1:0] status_t;

  // Request codes.
  typedef enum logic [OP_W-1:0] {
    OP_AT    = 2'd0,
    OP_AFTER = 2'd1,
    OP_MARK  = 2'd2,
    OP_TICK  = 2'd3
  } op_t;

  // Response status codes.
  localparam status_t ST_OK   = 2'd0;
  localparam status_t ST_DUP  = 2'd1;
  localparam status_t ST_FULL = 2'd2;

endpackage

FILE: rtl/tes_if.sv
// ----------------------------------------------------------------------------
// tes_in_if / tes_out_if
// Valid/ready channels for requests and results of the event scheduler.
// ----------------------------------------------------------------------------
interface tes_in_if #(
  parameter int unsigned TIME_BITS = tes_pkg::TIME_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic [tes_pkg::OP_W-1:0]      op;
  logic [tes_pkg::COMP_W-1:0]    component;
  logic [tes_pkg::SLOT_IN_W-1:0] timer_slot;
  logic [TIME_BITS-1:0]          time_value;
  logic [TIME_BITS-1:0]          now;

  modport source (output valid, op, component, timer_slot, time_value, now, input ready);
  modport sink   (input valid, op, component, timer_slot, time_value, now, output ready);
endinterface

interface tes_out_if;
  logic                         valid;
  logic                         ready;
  logic [tes_pkg::COMP_W-1:0]   component_out;
  logic                         has_component;
  logic                         last;
  logic [tes_pkg::STATUS_W-1:0] status;

  modport source (output valid, component_out, has_component, last, status, input ready);
  modport sink   (input valid, component_out, has_component, last, status, output ready);
endinterface

FILE: rtl/timed_event_scheduler.sv
// ----------------------------------------------------------------------------
// timed_event_scheduler
// Sorted timer queue with replace-on-reschedule and two banked ready lists.
// ----------------------------------------------------------------------------
// Channel | Dir | Transaction
// in_ch   | in  | op, component, timer_slot, time_value, now
// out_ch  | out | component_out, has_component, last, status
//
// One request is worked on at a time; in_ch.ready is high only when idle.
// A schedule walks the queue one entry per cycle, first for the same key to
// remove, then for the insert position. A mark walks the add list for a
// duplicate. A tick pops each due timer from the head into a mark walk, then
// swaps the banks and streams the execute list on out_ch. Reset is synchronous
// and needs no sweep. Stalls on out_ch hold the sequencer.
// ----------------------------------------------------------------------------
module timed_event_scheduler #(
  parameter int unsigned COMPONENTS  = tes_pkg::COMPONENTS_DEF,
  parameter int unsigned QUEUE_DEPTH = tes_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned TIMER_SLOTS = tes_pkg::TIMER_SLOTS_DEF,
  parameter int unsigned TIME_BITS   = tes_pkg::TIME_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  tes_in_if.sink    in_ch,
  tes_out_if.source out_ch
);

  localparam int unsigned QCW   = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned QAW   = $clog2(QUEUE_DEPTH);
  localparam int unsigned RCW   = $clog2(COMPONENTS + 1);
  localparam int unsigned RAW   = $clog2(COMPONENTS);
  localparam int unsigned IW    = (QCW > RCW) ? QCW : RCW;
  localparam int unsigned SLOTW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;

  typedef logic [TIME_BITS-1:0] time_t;
  typedef logic [SLOTW-1:0]     slot_t;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_FIND = 7'b0000010,
    S_POS  = 7'b0000100,
    S_MARK = 7'b0001000,
    S_POP  = 7'b0010000,
    S_EMIT = 7'b0100000,
    S_RESP = 7'b1000000
  } state_t;

  // Slot number reduced into the configured slot range.
  function automatic slot_t slot_reduce(input logic [tes_pkg::SLOT_IN_W-1:0] s);
    logic [tes_pkg::SLOT_IN_W:0] r;
    r = {1'b0, s};
    for (int k = 0; k < 4; k++) begin
      if (r >= (tes_pkg::SLOT_IN_W+1)'(TIMER_SLOTS)) begin
        r = r - (tes_pkg::SLOT_IN_W+1)'(TIMER_SLOTS);
      end
    end
    return slot_t'(r);
  endfunction

  // Timer queue and ready lists.
  time_t          q_time [QUEUE_DEPTH];
  tes_pkg::comp_t q_comp [QUEUE_DEPTH];
  slot_t          q_slot [QUEUE_DEPTH];
  logic [QCW-1:0] q_count;
  tes_pkg::comp_t r_ent [2][COMPONENTS];
  logic [RCW-1:0] r_cnt [2];
  logic           bank;

  // Sequencer registers.
  state_t           state;
  logic [IW-1:0]    idx;
  tes_pkg::comp_t   cur_comp;
  slot_t            cur_slot;
  time_t            cur_due;
  time_t            cur_now;
  logic             from_tick;
  tes_pkg::status_t cur_status;

  // Output register.
  logic             o_valid;
  tes_pkg::comp_t   o_comp;
  logic             o_has;
  logic             o_last;
  tes_pkg::status_t o_status;

  logic           out_free;
  logic           add_bank;
  logic [QAW-1:0] qi;
  logic [RAW-1:0] ri;
  logic [TIME_BITS:0] due_sum;
  time_t          due_after;

  // Queue edit controls from the sequencer.
  logic           rm_en;
  logic           ins_en;
  logic [QAW-1:0] edit_pos;

  assign out_free = !o_valid || out_ch.ready;
  assign add_bank = ~bank;
  assign qi       = idx[QAW-1:0];
  assign ri       = idx[RAW-1:0];

  // Saturating due time for schedule-after-delay.
  assign due_sum   = {1'b0, in_ch.now} + {1'b0, in_ch.time_value};
  assign due_after = due_sum[TIME_BITS] ? '1 : due_sum[TIME_BITS-1:0];

  assign in_ch.ready          = (state == S_IDLE);
  assign out_ch.valid         = o_valid;
  assign out_ch.component_out = o_comp;
  assign out_ch.has_component = o_has;
  assign out_ch.last          = o_last;
  assign out_ch.status        = o_status;

  // Queue edits chosen in the current state.
  always_comb begin
    rm_en    = 1'b0;
    ins_en   = 1'b0;
    edit_pos = qi;
    case (state)
      S_FIND: begin
        if (IW'(q_count) != idx && q_comp[qi] == cur_comp &&
            q_slot[qi] == cur_slot) begin
          rm_en = 1'b1;
        end
      end
      S_POS: begin
        if (IW'(q_count) == idx || !(q_time[qi] < cur_due)) begin
          ins_en = 1'b1;
        end
      end
      S_POP: begin
        if (q_count != '0 && q_time[0] <= cur_now) begin
          rm_en    = 1'b1;
          edit_pos = '0;
        end
      end
      default: begin
      end
    endcase
  end

  // Queue storage: parallel shift on remove and insert.
  always_ff @(posedge clk) begin
    for (int j = 0; j < QUEUE_DEPTH; j++) begin
      if (rm_en && QAW'(j) >= edit_pos && j < QUEUE_DEPTH - 1) begin
        q_time[j] <= q_time[j+1];
        q_comp[j] <= q_comp[j+1];
        q_slot[j] <= q_slot[j+1];
      end else if (ins_en && QAW'(j) == edit_pos) begin
        q_time[j] <= cur_due;
        q_comp[j] <= cur_comp;
        q_slot[j] <= cur_slot;
      end else if (ins_en && QAW'(j) > edit_pos && j > 0) begin
        q_time[j] <= q_time[j-1];
        q_comp[j] <= q_comp[j-1];
        q_slot[j] <= q_slot[j-1];
      end
    end
  end

  // Ready list entries: append in the mark walk.
  always_ff @(posedge clk) begin
    if (state == S_MARK && IW'(r_cnt[add_bank]) == idx &&
        r_cnt[add_bank] != RCW'(COMPONENTS)) begin
      r_ent[add_bank][ri] <= cur_comp;
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      q_count   <= '0;
      r_cnt[0]  <= '0;
      r_cnt[1]  <= '0;
      bank      <= 1'b0;
      o_valid   <= 1'b0;
      idx       <= '0;
      from_tick <= 1'b0;
    end else begin
      if (out_ch.ready) begin
        o_valid <= 1'b0;
      end
      if (rm_en) begin
        q_count <= q_count - 1'b1;
      end
      if (ins_en) begin
        q_count <= q_count + 1'b1;
      end
      case (state)
        S_IDLE: begin
          if (in_ch.valid) begin
            cur_comp  <= in_ch.component;
            cur_slot  <= slot_reduce(in_ch.timer_slot);
            cur_now   <= in_ch.now;
            cur_due   <= (in_ch.op == tes_pkg::OP_AFTER) ? due_after : in_ch.time_value;
            idx       <= '0;
            from_tick <= 1'b0;
            case (in_ch.op)
              tes_pkg::OP_AT, tes_pkg::OP_AFTER: state <= S_FIND;
              tes_pkg::OP_MARK:                  state <= S_MARK;
              default:                           state <= S_POP;
            endcase
          end
        end
        // Look for the same key already queued.
        S_FIND: begin
          if (IW'(q_count) == idx) begin
            if (q_count == QCW'(QUEUE_DEPTH)) begin
              cur_status <= tes_pkg::ST_FULL;
              state      <= S_RESP;
            end else begin
              idx   <= '0;
              state <= S_POS;
            end
          end else if (rm_en) begin
            idx   <= '0;
            state <= S_POS;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        // Find the first entry not earlier than the new due time.
        S_POS: begin
          if (ins_en) begin
            cur_status <= tes_pkg::ST_OK;
            state      <= S_RESP;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        // Duplicate search and append on the add list.
        S_MARK: begin
          if (IW'(r_cnt[add_bank]) == idx) begin
            if (r_cnt[add_bank] == RCW'(COMPONENTS)) begin
              cur_status <= tes_pkg::ST_FULL;
            end else begin
              r_cnt[add_bank] <= r_cnt[add_bank] + 1'b1;
              cur_status      <= tes_pkg::ST_OK;
            end
            state <= from_tick ? S_POP : S_RESP;
          end else if (r_ent[add_bank][ri] == cur_comp) begin
            cur_status <= tes_pkg::ST_DUP;
            state      <= from_tick ? S_POP : S_RESP;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        // Pop due timers from the head, then swap banks.
        S_POP: begin
          idx <= '0;
          if (rm_en) begin
            cur_comp  <= q_comp[0];
            from_tick <= 1'b1;
            state     <= S_MARK;
          end else begin
            bank        <= ~bank;
            r_cnt[bank] <= '0;
            state       <= S_EMIT;
          end
        end
        // Stream out the execute list.
        S_EMIT: begin
          if (out_free) begin
            o_valid  <= 1'b1;
            o_status <= tes_pkg::ST_OK;
            if (r_cnt[bank] == '0) begin
              o_comp <= '0;
              o_has  <= 1'b0;
              o_last <= 1'b1;
              state  <= S_IDLE;
            end else begin
              o_comp <= r_ent[bank][ri];
              o_has  <= 1'b1;
              o_last <= (idx + 1'b1 == IW'(r_cnt[bank]));
              idx    <= idx + 1'b1;
              if (idx + 1'b1 == IW'(r_cnt[bank])) begin
                state <= S_IDLE;
              end
            end
          end
        end
        // Single status result.
        S_RESP: begin
          if (out_free) begin
            o_valid  <= 1'b1;
            o_comp   <= '0;
            o_has    <= 1'b0;
            o_last   <= 1'b1;
            o_status <= cur_status;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
